@@ rtl/imh_pkg.sv @@
// Package for the indexed max-heap core: sizes, operation and status codes,
// sequencer states and the packed layouts of the stream payloads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

    localparam int CAPACITY = 1024;
    localparam int ID_W     = 10;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = SLOT_W + 2;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int IN_TDATA_W  = ((ID_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 2 * ID_W + 1 + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_PUSH   = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_REMOVE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_DUP    = 2'd2,
        STATUS_ABSENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_UP_RD,
        ST_UP_CMP,
        ST_CH_RD,
        ST_CH_WR,
        ST_LAST_RD,
        ST_LAST_LAT,
        ST_DN_RD,
        ST_DN_CMP,
        ST_TOP_RD,
        ST_FINISH
    } state_t;

    // Result payload, last member in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               top_valid;
        logic [ID_W-1:0]    top_item;
        logic [ID_W-1:0]    taken_item;
    } out_data_t;

endpackage

`default_nettype wire

@@ rtl/indexed_max_heap_core.sv @@
// Indexed max-heap core: heap slot memory, position map memory and the
// sequencer that walks sift-up, ancestor shift and sift-down one level at a time.
// Depends on imh_pkg.
//
// Usage:
//   Input channel s_*: s_tuser carries the operation (clear, push, pop root,
//   remove named id), s_tdata carries the item id. Output channel m_*: one
//   result item per input item, status in m_tuser, the popped or removed id,
//   the new root, a root-valid flag and the entry count in m_tdata.
//   One item is worked on at a time; s_tready is high only while the
//   sequencer waits for work. Every item passes LOOKUP, CHECK, TOP_RD and
//   FINISH; a push climbs with UP_RD/UP_CMP, a pop reads the last entry
//   (LAST_RD, LAST_LAT) and descends with DN_RD/DN_CMP, and a remove first
//   shifts ancestors down with CH_RD/CH_WR and then descends like a pop.
//   With 1024 entries (eleven levels) each level takes a read state and a
//   compare/write state around the registered slot read.
//   The result sits in an output register; the next item is accepted while it
//   waits, and a stalled receiver only holds the sequencer in its last state.
//   Reset zeroes the count and empties the output register. No clearing pass
//   runs: an id counts as present only when its map entry points below the
//   count at a slot that holds the id itself.
`timescale 1ns / 1ps
`default_nettype none

module indexed_max_heap_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [imh_pkg::IN_TDATA_W-1:0]  s_tdata,   // [9:0] item_id
    input  wire  [imh_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [9:0] taken_item, [19:10] top_item, [20] top_valid, [31:21] entry_count
    output logic [imh_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [imh_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);
    import imh_pkg::*;

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]     last_reg, last_next;
    logic [ID_W-1:0]     taken_reg, taken_next;
    status_t             status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    out_data_t           out_reg, out_next;
    status_t             m_status_reg, m_status_next;

    logic [ID_W-1:0]     hs_mem [CAPACITY];
    logic [SLOT_W-1:0]   pm_mem [2**ID_W];
    logic [ID_W-1:0]     hs_rd_a_reg, hs_rd_b_reg;
    logic [SLOT_W-1:0]   pm_rd_reg;
    logic [SLOT_W-1:0]   hs_rd_a_addr, hs_rd_b_addr;
    logic [ID_W-1:0]     pm_rd_addr;
    logic                place_we;
    logic [SLOT_W-1:0]   place_slot;
    logic [ID_W-1:0]     place_id;

    logic                accept;
    logic                present;
    logic                full;
    logic                empty;
    logic [SLOT_W-1:0]   par;
    logic [CHILD_W-1:0]  child;
    logic [CHILD_W-1:0]  other;
    logic [CHILD_W-1:0]  total_ext;
    logic                take_other;
    logic [ID_W-1:0]     sel_val;
    logic [CHILD_W-1:0]  sel_slot;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign full      = (total_reg == CNT_W'(CAPACITY));
    assign empty     = (total_reg == '0);
    // Valid in CHECK: map entry points inside the heap at a slot holding this id.
    assign present   = (CNT_W'(pm_rd_reg) < total_reg) && (hs_rd_a_reg == id_reg);
    assign par       = (idx_reg - SLOT_W'(1)) >> 1;
    assign child     = {1'b0, idx_reg, 1'b1};
    assign other     = child + CHILD_W'(1);
    assign total_ext = CHILD_W'(total_reg);
    // Valid in DN_CMP: pick the larger child, the right one on a tie.
    assign take_other = (other < total_ext) && (hs_rd_b_reg >= hs_rd_a_reg);
    assign sel_val    = take_other ? hs_rd_b_reg : hs_rd_a_reg;
    assign sel_slot   = take_other ? other : child;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);
    assign m_tuser  = m_status_reg;

    // Slot and map memories, registered reads.
    always_ff @(posedge aclk) begin
        if (place_we) begin
            hs_mem[place_slot] <= place_id;
        end
        hs_rd_a_reg <= hs_mem[hs_rd_a_addr];
        hs_rd_b_reg <= hs_mem[hs_rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (place_we) begin
            pm_mem[place_id] <= place_slot;
        end
        pm_rd_reg <= pm_mem[pm_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        taken_reg    <= taken_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
        m_status_reg <= m_status_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK: begin
                case (func_reg)
                    FUNC_PUSH: begin
                        if (present) begin
                            state_next = ST_TOP_RD;
                        end else if (full) begin
                            state_next = ST_TOP_RD;
                        end else begin
                            state_next = ST_UP_RD;
                        end
                    end
                    FUNC_POP: begin
                        if (empty) begin
                            state_next = ST_TOP_RD;
                        end else begin
                            state_next = ST_LAST_RD;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (present) begin
                            state_next = ST_CH_RD;
                        end else begin
                            state_next = ST_TOP_RD;
                        end
                    end
                    default: state_next = ST_TOP_RD;
                endcase
            end
            ST_UP_RD: begin
                if (idx_reg == '0) begin
                    state_next = ST_TOP_RD;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (hs_rd_a_reg >= id_reg) begin
                    state_next = ST_TOP_RD;
                end else begin
                    state_next = ST_UP_RD;
                end
            end
            ST_CH_RD: begin
                if (idx_reg == '0) begin
                    state_next = ST_LAST_RD;
                end else begin
                    state_next = ST_CH_WR;
                end
            end
            ST_CH_WR: state_next = ST_CH_RD;
            ST_LAST_RD: begin
                if (empty) begin
                    state_next = ST_TOP_RD;
                end else begin
                    state_next = ST_LAST_LAT;
                end
            end
            ST_LAST_LAT: state_next = ST_DN_RD;
            ST_DN_RD: begin
                if (child >= total_ext) begin
                    state_next = ST_TOP_RD;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (last_reg >= sel_val) begin
                    state_next = ST_TOP_RD;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_TOP_RD: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        func_next     = func_reg;
        id_next       = id_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        taken_next    = taken_reg;
        status_next   = status_reg;
        out_next      = out_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg;
        hs_rd_a_addr  = '0;
        hs_rd_b_addr  = '0;
        pm_rd_addr    = id_reg;
        place_we      = 1'b0;
        place_slot    = idx_reg;
        place_id      = id_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                pm_rd_addr = s_tdata[ID_W-1:0];
                if (accept) begin
                    func_next = func_t'(s_tuser);
                    id_next   = s_tdata[ID_W-1:0];
                end
            end
            ST_LOOKUP: begin
                hs_rd_a_addr = pm_rd_reg;
            end
            ST_CHECK: begin
                taken_next  = '0;
                status_next = STATUS_OK;
                case (func_reg)
                    FUNC_CLEAR: begin
                        total_next = '0;
                    end
                    FUNC_PUSH: begin
                        if (present) begin
                            status_next = STATUS_DUP;
                        end else if (full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            idx_next   = SLOT_W'(total_reg);
                            total_next = total_reg + CNT_W'(1);
                        end
                    end
                    FUNC_POP: begin
                        if (empty) begin
                            status_next = STATUS_ABSENT;
                        end else begin
                            taken_next = hs_rd_b_reg;
                            total_next = total_reg - CNT_W'(1);
                        end
                    end
                    FUNC_REMOVE: begin
                        if (present) begin
                            taken_next = id_reg;
                            idx_next   = pm_rd_reg;
                            total_next = total_reg - CNT_W'(1);
                        end else begin
                            status_next = STATUS_ABSENT;
                        end
                    end
                    default: status_next = STATUS_ABSENT;
                endcase
            end
            ST_UP_RD: begin
                if (idx_reg == '0) begin
                    place_we = 1'b1;
                end else begin
                    hs_rd_a_addr = par;
                end
            end
            ST_UP_CMP: begin
                place_we = 1'b1;
                if (!(hs_rd_a_reg >= id_reg)) begin
                    // move the parent down and climb
                    place_id = hs_rd_a_reg;
                    idx_next = par;
                end
            end
            ST_CH_RD: begin
                if (idx_reg != '0) begin
                    hs_rd_a_addr = par;
                end
            end
            ST_CH_WR: begin
                place_we = 1'b1;
                place_id = hs_rd_a_reg;
                idx_next = par;
            end
            ST_LAST_RD: begin
                hs_rd_a_addr = SLOT_W'(total_reg);
                idx_next     = '0;
            end
            ST_LAST_LAT: begin
                last_next = hs_rd_a_reg;
            end
            ST_DN_RD: begin
                if (child >= total_ext) begin
                    place_we = 1'b1;
                    place_id = last_reg;
                end else begin
                    hs_rd_a_addr = SLOT_W'(child);
                    hs_rd_b_addr = SLOT_W'(other);
                end
            end
            ST_DN_CMP: begin
                place_we = 1'b1;
                if (last_reg >= sel_val) begin
                    place_id = last_reg;
                end else begin
                    // pull the larger child up and descend
                    place_id = sel_val;
                    idx_next = SLOT_W'(sel_slot);
                end
            end
            ST_TOP_RD: begin
                hs_rd_a_addr = '0;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next          = 1'b1;
                    m_status_next          = status_reg;
                    out_next.taken_item    = taken_reg;
                    out_next.top_item      = empty ? '0 : hs_rd_a_reg;
                    out_next.top_valid     = !empty;
                    out_next.entry_count   = COUNT_W'(total_reg);
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted item did not start a lookup");

    a_count_only_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CHECK) |=> $stable(total_reg))
        else $error("entry count changed outside the check state");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_top_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_reg.top_valid == (out_reg.entry_count != '0)))
        else $error("root valid flag disagrees with entry count");

    a_error_has_no_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STATUS_OK)) |-> (out_reg.taken_item == '0))
        else $error("failed operation reports a taken item");
`endif

endmodule

`default_nettype wire

@@ tb/indexed_max_heap_core_test.sv @@
// Self-checking testbench for indexed_max_heap_core: clear, push, pop and remove
// items go through a mirror heap and the block's results are compared against it.
// Depends on imh_pkg and the indexed_max_heap_core RTL.
`timescale 1ns / 1ps

module indexed_max_heap_core_test;

    import imh_pkg::*;

    localparam int RUN_LIMIT = 800000;
    localparam int ID_SPACE  = 1 << ID_W;

    typedef struct {
        func_t           op;
        logic [ID_W-1:0] id;
    } heap_req_t;

    typedef struct {
        status_t            status;
        logic [ID_W-1:0]    taken;
        logic [ID_W-1:0]    top;
        logic               top_ok;
        logic [COUNT_W-1:0] count;
    } heap_reply_t;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_mode_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]      s_tuser  = FUNC_CLEAR;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    indexed_max_heap_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Mirror of the heap contents
    logic [ID_W-1:0] mirror_slot [CAPACITY];
    int              mirror_pos [ID_SPACE];
    bit              mirror_present [ID_SPACE];
    int              mirror_total = 0;

    heap_req_t   ops_to_send[$];
    heap_reply_t replies_due[$];

    logic     in_fire    = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       mode_left  = 0;
    int       cycle_count = 0;

    int items_sent    = 0;
    int replies_seen  = 0;
    int mismatch_cnt  = 0;
    int peak_total    = 0;
    int dup_rejects   = 0;
    int empty_rejects = 0;

    function automatic void mirror_place(int slot, logic [ID_W-1:0] id);
        mirror_slot[slot] = id;
        mirror_pos[id]    = slot;
    endfunction

    // Remove the root and sift the former last entry down; heap must be non-empty.
    function automatic logic [ID_W-1:0] mirror_take_root();
        logic [ID_W-1:0] root;
        logic [ID_W-1:0] tail;
        int              idx;
        int              kid;
        root = mirror_slot[0];
        mirror_total--;
        mirror_present[root] = 1'b0;
        if (mirror_total == 0)
            return root;
        tail = mirror_slot[mirror_total];
        idx  = 0;
        kid  = 1;
        while (kid < mirror_total) begin
            if (kid + 1 < mirror_total && mirror_slot[kid+1] >= mirror_slot[kid])
                kid++;
            if (tail >= mirror_slot[kid])
                break;
            mirror_place(idx, mirror_slot[kid]);
            idx = kid;
            kid = 2 * idx + 1;
        end
        mirror_place(idx, tail);
        return root;
    endfunction

    function automatic heap_reply_t apply_heap_op(func_t op, logic [ID_W-1:0] id);
        heap_reply_t res;
        int          idx;
        int          par;
        res.status = STATUS_OK;
        res.taken  = '0;
        case (op)
            FUNC_CLEAR: begin
                foreach (mirror_present[i])
                    mirror_present[i] = 1'b0;
                mirror_total = 0;
            end
            FUNC_PUSH: begin
                if (mirror_present[id]) begin
                    res.status = STATUS_DUP;
                end else if (mirror_total >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    idx = mirror_total;
                    mirror_total++;
                    while (idx > 0) begin
                        par = (idx - 1) / 2;
                        if (mirror_slot[par] >= id)
                            break;
                        mirror_place(idx, mirror_slot[par]);
                        idx = par;
                    end
                    mirror_place(idx, id);
                    mirror_present[id] = 1'b1;
                end
            end
            FUNC_POP: begin
                if (mirror_total == 0)
                    res.status = STATUS_ABSENT;
                else
                    res.taken = mirror_take_root();
            end
            default: begin
                if (!mirror_present[id] || mirror_total == 0) begin
                    res.status = STATUS_ABSENT;
                end else begin
                    // shift every ancestor down one level, then pop the victim off the root
                    idx = mirror_pos[id];
                    if (idx >= mirror_total)
                        idx = mirror_total - 1;
                    while (idx > 0) begin
                        par = (idx - 1) / 2;
                        mirror_place(idx, mirror_slot[par]);
                        idx = par;
                    end
                    mirror_place(0, id);
                    res.taken = mirror_take_root();
                end
            end
        endcase
        res.top_ok = (mirror_total != 0);
        res.top    = res.top_ok ? mirror_slot[0] : '0;
        res.count  = COUNT_W'(mirror_total);
        if (mirror_total > peak_total)
            peak_total = mirror_total;
        if (res.status == STATUS_DUP)
            dup_rejects++;
        if (res.status == STATUS_ABSENT)
            empty_rejects++;
        return res;
    endfunction

    function automatic void queue_op(func_t op, int id);
        heap_req_t req;
        req.op = op;
        req.id = ID_W'(id);
        ops_to_send.push_back(req);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sender: bursts of items separated by random gaps
    always @(negedge aclk) begin : drive_inputs
        heap_req_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (ops_to_send.size() != 0) begin
                next_req = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.op;
                s_tdata  <= {{(IN_TDATA_W-ID_W){1'b0}}, next_req.id};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch between always ready, choppy and mostly stalled
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 2));
            mode_left <= $urandom_range(32, 256);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_CHOPPY: m_tready <= $urandom_range(0, 1);
            default:   m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin : watch_channels
        out_data_t   got;
        heap_reply_t want;
        in_fire <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            replies_due.push_back(apply_heap_op(func_t'(s_tuser), s_tdata[ID_W-1:0]));
            items_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = out_data_t'(m_tdata[OUT_DATA_W-1:0]);
            replies_seen++;
            if (replies_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: status %0d taken %0d top %0d/%0d count %0d",
                             m_tuser, got.taken_item, got.top_item, got.top_valid,
                             got.entry_count);
            end else begin
                want = replies_due.pop_front();
                if (m_tuser !== want.status || got.taken_item !== want.taken ||
                    got.top_item !== want.top || got.top_valid !== want.top_ok ||
                    got.entry_count !== want.count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result %0d: expected status %0d taken %0d top %0d/%0d ",
                                  "count %0d, got status %0d taken %0d top %0d/%0d count %0d"},
                                 replies_seen, want.status, want.taken, want.top,
                                 want.top_ok, want.count, m_tuser, got.taken_item,
                                 got.top_item, got.top_valid, got.entry_count);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, replies_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : main_flow
        logic [ID_W-1:0] perm [ID_SPACE];
        logic [ID_W-1:0] tmp;
        int              j;
        int              window;
        int              pick;
        int              id;
        func_t           op;

        // Directed: empty heap, id extremes, duplicates, root/leaf/mid removal, clear
        queue_op(FUNC_POP, 0);
        queue_op(FUNC_REMOVE, 5);
        queue_op(FUNC_PUSH, 0);
        queue_op(FUNC_PUSH, 1023);
        queue_op(FUNC_PUSH, 1023);
        queue_op(FUNC_PUSH, 512);
        queue_op(FUNC_PUSH, 511);
        queue_op(FUNC_REMOVE, 1023);
        queue_op(FUNC_REMOVE, 0);
        queue_op(FUNC_REMOVE, 0);
        queue_op(FUNC_POP, 1023);
        queue_op(FUNC_POP, 0);
        queue_op(FUNC_POP, 0);
        queue_op(FUNC_PUSH, 341);
        queue_op(FUNC_PUSH, 682);
        queue_op(FUNC_PUSH, 100);
        queue_op(FUNC_PUSH, 700);
        queue_op(FUNC_PUSH, 50);
        queue_op(FUNC_REMOVE, 341);
        queue_op(FUNC_REMOVE, 50);
        queue_op(FUNC_CLEAR, 682);
        queue_op(FUNC_POP, 0);
        queue_op(FUNC_REMOVE, 700);
        queue_op(FUNC_PUSH, 682);

        // Random mix; ids mostly from a sliding window so removes and duplicates hit
        window = 0;
        for (int n = 0; n < 460; n++) begin
            if (n % 40 == 0)
                window = $urandom_range(0, ID_SPACE - 48);
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = FUNC_CLEAR;
            else if (pick < 50)
                op = FUNC_PUSH;
            else if (pick < 70)
                op = FUNC_POP;
            else
                op = FUNC_REMOVE;
            if ($urandom_range(0, 9) < 6)
                id = window + $urandom_range(0, 47);
            else
                id = $urandom_range(0, ID_SPACE - 1);
            queue_op(op, id);
        end

        // Fill to capacity with a shuffled permutation of every id
        for (int i = 0; i < ID_SPACE; i++)
            perm[i] = ID_W'(i);
        for (int i = ID_SPACE - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < ID_SPACE; i++)
            queue_op(FUNC_PUSH, perm[i]);

        // Work the full heap at its deepest
        for (int n = 0; n < 12; n++)
            queue_op(FUNC_PUSH, $urandom_range(0, ID_SPACE - 1));
        for (int n = 0; n < 40; n++) begin
            pick = $urandom_range(0, 9);
            op   = (pick < 5) ? FUNC_REMOVE : (pick < 8) ? FUNC_POP : FUNC_PUSH;
            queue_op(op, $urandom_range(0, ID_SPACE - 1));
        end
        queue_op(FUNC_CLEAR, 0);
        queue_op(FUNC_POP, 0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Check at the rising edge, where the sender's queue and tvalid agree
        while (ops_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (64) @(negedge aclk);

        $display("%0d items sent, %0d results checked; heap peaked at %0d entries",
                 items_sent, replies_seen, peak_total);
        $display("%0d duplicate pushes, %0d empty or absent rejects, %0d mismatches",
                 dup_rejects, empty_rejects, mismatch_cnt);
        if (mismatch_cnt == 0 && replies_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
